@@ hdl/sfp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the start/length/xor frame parser
// no dependencies; imported by every module of the block

package sfp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_AW    = $clog2(MAX_PAYLOAD);

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int STAT_W = 2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd239;
    localparam logic [BYTE_W-1:0] MAX_LEN_BYTE   = BYTE_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0]  MAX_LEN        = LEN_W'(MAX_PAYLOAD);

    // result status codes
    localparam logic [STAT_W-1:0] ST_DATA  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERROR = 2'd2;

    typedef enum logic [5:0] {
        S_HUNT     = 6'b000001,
        S_LEN      = 6'b000010,
        S_DATA     = 6'b000100,
        S_CHECK    = 6'b001000,
        S_DRAIN_RD = 6'b010000,
        S_DRAIN_WR = 6'b100000
    } t_state;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [BYTE_W-1:0]   wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  out_index;
        logic [LEN_W-1:0]  frame_length;
        logic              last;
    } t_result;

endpackage

@@ hdl/sfp_store.sv @@
`timescale 1ns / 1ps
// payload memory: one write port, one read port, registered read data
// depends on sfp_pkg

module sfp_store (
    input  logic                      i_clk,
    input  sfp_pkg::t_mem_req         i_req,
    output logic [sfp_pkg::BYTE_W-1:0] o_rdata
);
    import sfp_pkg::*;

    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sfp_ctrl.sv @@
`timescale 1ns / 1ps
// frame parser sequencer: hunt/length/payload/check phases, drain of the
// payload memory and the result register; depends on sfp_pkg

module sfp_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sfp_pkg::BYTE_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [sfp_pkg::BYTE_W-1:0] i_in_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output sfp_pkg::t_result           o_out,
    output sfp_pkg::t_mem_req          o_mem_req,
    input  logic [sfp_pkg::BYTE_W-1:0] i_mem_rdata
);
    import sfp_pkg::*;

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_start_byte;
    logic [LEN_W-1:0]  r_held, n_held;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              in_fire;
    logic [LEN_W-1:0]  fill_inc;
    logic              out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_HUNT) || (r_state == S_LEN) || (r_state == S_DATA)
                        || ((r_state == S_CHECK) && !r_out_valid);
    assign in_fire    = i_in_valid && o_in_ready;
    assign fill_inc   = r_fill + LEN_W'(1);

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_fill      = r_fill;
        n_xor       = r_xor;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_mem_req   = '{we: 1'b0, waddr: r_fill[STORE_AW-1:0], wdata: i_in_byte,
                        re: 1'b0, raddr: r_fill[STORE_AW-1:0]};
        case (r_state)
            S_HUNT: begin
                if (in_fire && i_in_byte == r_start_byte) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (in_fire) begin
                    if (i_in_byte > MAX_LEN_BYTE) begin
                        n_state = S_HUNT;
                    end else begin
                        n_held  = i_in_byte[LEN_W-1:0];
                        n_fill  = '0;
                        n_xor   = i_in_byte;
                        n_state = (i_in_byte[LEN_W-1:0] == '0) ? S_CHECK : S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (in_fire) begin
                    o_mem_req.we = (r_fill < MAX_LEN);
                    n_xor        = r_xor ^ i_in_byte;
                    n_fill       = fill_inc;
                    if (fill_inc >= r_held) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (in_fire) begin
                    n_state = S_HUNT;
                    if (i_in_byte != r_xor) begin
                        n_out       = '{status: ST_ERROR, out_byte: '0, out_index: '0,
                                        frame_length: r_held, last: 1'b1};
                        n_out_valid = 1'b1;
                    end else if (r_held == '0) begin
                        n_out       = '{status: ST_EMPTY, out_byte: '0, out_index: '0,
                                        frame_length: '0, last: 1'b1};
                        n_out_valid = 1'b1;
                    end else begin
                        n_fill  = '0;
                        n_state = S_DRAIN_RD;
                    end
                end
            end
            S_DRAIN_RD: begin
                o_mem_req.re = 1'b1;
                n_state      = S_DRAIN_WR;
            end
            S_DRAIN_WR: begin
                // read data stays put until the next read, so wait here on a stall
                if (out_free) begin
                    n_out       = '{status: ST_DATA, out_byte: i_mem_rdata, out_index: r_fill,
                                    frame_length: r_held, last: (fill_inc == r_held)};
                    n_out_valid = 1'b1;
                    n_fill      = fill_inc;
                    n_state     = (fill_inc == r_held) ? S_HUNT : S_DRAIN_RD;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_HUNT;
            r_start_byte <= START_BYTE_RST;
            r_held       <= '0;
            r_fill       <= '0;
            r_xor        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_fill      <= n_fill;
            r_xor       <= n_xor;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // memory is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.we && o_mem_req.re))
        else $error("payload memory written and read together");

    // the drain index never runs past the frame length
    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN_RD || r_state == S_DRAIN_WR) |-> (r_fill < r_held))
        else $error("drain index beyond frame length");

    // a check byte is taken only with the result register empty
    a_check_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_state == S_CHECK) |-> !r_out_valid)
        else $error("check byte accepted over a pending result");

    // a data result loads from a read issued on entry to the load wait
    a_read_before_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN_WR) |-> ($past(o_mem_req.re) || $past(r_state == S_DRAIN_WR)))
        else $error("drain load without preceding read");

endmodule

@@ hdl/sop_length_xor_frame_parser_unit.sv @@
`timescale 1ns / 1ps
// top level of the start/length/xor frame parser
// depends on sfp_pkg, sfp_store, sfp_ctrl

// Frame parser for a byte stream. Each input item is one received byte. The
// block hunts for the start byte (register, reset 0xEF), then takes a length
// byte; a length above 32 drops back to hunting. The payload bytes go into a
// 32 x 8 memory, then a check byte is compared with the xor of the length and
// the payload. A good frame comes out as one item per payload byte with its
// index, the frame length and tlast on the final one; a good empty frame gives
// a single empty status item, and a mismatch a single checksum-error item.
// Timing: every byte that ends no frame is taken as soon as it is offered, also
// while an earlier result still waits on the output. The check byte of a good
// frame holds off input while the payload is read back, one byte per read of
// the memory's single read port followed by a load of the output register; a
// downstream stall stretches that. The payload memory has no reset and no
// clearing pass: every entry is written within a frame before it is read.

module sop_length_xor_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: start byte
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [13:8] out_index,
                                        // [19:14] frame_length, [23:20] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // last result of the frame
);
    import sfp_pkg::*;

    t_mem_req          mem_req;
    logic [BYTE_W-1:0] mem_rdata;
    t_result           res;

    // payload memory, filled during the payload phase and read back on a match
    sfp_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // phase sequencer, checksum and result register
    sfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // pack the result fields, lowest field first, padded to whole bytes
    assign m_axis_tdata = {4'b0000, res.frame_length, res.out_index, res.out_byte};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

endmodule
